// ----- design/bltd_pkg.sv -----
`timescale 1ns / 1ps
package bltd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [20:0] CP_ASCII_LO = 21'd33;
  localparam logic [20:0] CP_ASCII_HI = 21'd126;
  localparam logic [20:0] CP_LAT1_LO = 21'd161;
  localparam logic [20:0] CP_LAT1_HI = 21'd172;
  localparam logic [20:0] CP_LAT2_LO = 21'd174;
  localparam logic [20:0] CP_LAT2_HI = 21'h0000FF;
  localparam logic [20:0] CP_SHIFT_LO = 21'h000100;
  localparam logic [20:0] CP_SHIFT_HI = 21'h000143;
  localparam logic [20:0] CP_ONE_MAX = 21'h00007F;
  localparam logic [20:0] CP_TWO_MAX = 21'h0007FF;
  localparam logic [20:0] CP_THREE_MAX = 21'h00FFFF;

  // one decoded request for the back end: up to four bytes, cnt is count minus one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
    logic            err;
  } job_t;

  function automatic job_t encode_job(input logic [20:0] cp, input logic last);
    job_t       j;
    logic [6:0] n;
    j = '0;
    n = cp[6:0];
    j.last = last;
    if ((cp >= CP_ASCII_LO && cp <= CP_ASCII_HI) ||
        (cp >= CP_LAT1_LO && cp <= CP_LAT1_HI) ||
        (cp >= CP_LAT2_LO && cp <= CP_LAT2_HI)) begin
      j.bytes[0] = cp[7:0];
    end else if (cp >= CP_SHIFT_LO && cp <= CP_SHIFT_HI) begin
      if (n <= 7'd32) begin
        j.bytes[0] = {1'b0, n};
      end else if (n <= 7'd66) begin
        j.bytes[0] = {1'b0, n} + 8'd94;
      end else begin
        j.bytes[0] = 8'd173;
      end
    end else if (cp <= CP_ONE_MAX) begin
      j.bytes[0] = cp[7:0];
    end else if (cp <= CP_TWO_MAX) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.cnt = 2'd1;
    end else if (cp <= CP_THREE_MAX) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.cnt = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.cnt = 2'd3;
    end
    return j;
  endfunction

endpackage

// ----- design/bltd_front.sv -----
`timescale 1ns / 1ps
module bltd_front import bltd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       push,
  output job_t       job
);

  logic [1:0]  pending, pending_next;
  logic [20:0] partial, partial_next;
  logic        failed, failed_next;
  logic        accept;
  logic        done;
  logic        bad;
  logic [20:0] cp;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  always_comb begin
    pending_next = pending;
    partial_next = partial;
    failed_next = failed;
    done = 1'b0;
    bad = 1'b0;
    cp = partial;
    if (!failed) begin
      if (pending == 2'd0) begin
        if (in_byte[7] == 1'b0) begin
          cp = {13'd0, in_byte};
          done = 1'b1;
        end else if (in_byte[7:5] == 3'b110) begin
          partial_next = {16'd0, in_byte[4:0]};
          pending_next = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
          partial_next = {17'd0, in_byte[3:0]};
          pending_next = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          partial_next = {18'd0, in_byte[2:0]};
          pending_next = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else if (in_byte[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        cp = {partial[14:0], in_byte[5:0]};
        partial_next = cp;
        pending_next = pending - 2'd1;
        done = (pending == 2'd1);
      end
      if (bad) begin
        failed_next = 1'b1;
        pending_next = 2'd0;
        partial_next = '0;
      end else if (done) begin
        partial_next = '0;
      end
    end
    if (in_last && (failed_next || pending_next != 2'd0)) begin
      job = '0;
      job.last = 1'b1;
      job.err = 1'b1;
      push = accept;
    end else begin
      job = encode_job(cp, in_last);
      push = accept && done;
    end
    if (in_last) begin
      pending_next = 2'd0;
      partial_next = '0;
      failed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= '0;
      failed <= 1'b0;
    end else if (accept) begin
      pending <= pending_next;
      partial <= partial_next;
      failed <= failed_next;
    end
  end

endmodule

// ----- design/bltd_queue.sv -----
`timescale 1ns / 1ps
module bltd_queue import bltd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full = (count == QDEPTH[QAW:0]);
  assign empty = (count == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QDEPTH[QAW:0])
    else $error("queue count out of range");
`endif

endmodule

// ----- design/bltd_back.sv -----
`timescale 1ns / 1ps
module bltd_back import bltd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);

  logic [1:0] idx;
  logic       load;
  logic       final_byte;

  assign load = !out_valid || !out_stall;
  assign final_byte = (idx == head.cnt);
  assign pop = load && !q_empty && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= final_byte ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_byte <= head.bytes[idx];
      out_last <= head.last && final_byte;
      out_error <= head.err;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx <= head.cnt)
    else $error("byte index past end of request");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> idx == 2'd0)
    else $error("byte index not cleared with empty queue");
`endif

endmodule

// ----- design/byte_level_token_decoder.sv -----
`timescale 1ns / 1ps
// a result passes through a request queue entry and then the back end output register
// throughput: one input byte per cycle while the queue is not full; the back end sends
// one byte per cycle unless stalled; an n-byte codepoint holds the output until all n are out
// a four-entry request queue lets the decoder keep taking bytes while the output drains
// reset: synchronous rst clears the decode state, the queue and the output valid
module byte_level_token_decoder import bltd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  bltd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  bltd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  bltd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule
